[rtl/core/dsc_pkg.sv]
// Package with the shared types and constants of the scaled decimal comparator.
package dsc_pkg;

    localparam int SCALE_W = 6;
    localparam int MAG_W   = 128;
    localparam int IN_W    = 272;
    localparam int OUT_W   = 8;

    typedef enum logic [1:0] {
        ORDER_LESS    = 2'd0,
        ORDER_EQUAL   = 2'd1,
        ORDER_GREATER = 2'd2
    } t_order;

    typedef struct packed {
        logic               valid;
        logic               ovf;
        logic [SCALE_W-1:0] cnt;
        logic               swap;
        logic               neg;
        logic               sign_diff;
        logic               lneg;
    } t_stage_ctl;

endpackage

[rtl/core/dsc_mul10_stage.sv]
// One pipeline stage: multiplies side A by ten while cnt > 0 and no ovf.
module dsc_mul10_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  dsc_pkg::t_stage_ctl              i_ctl,
    input  logic [dsc_pkg::MAG_W-1:0]        i_mag_a,
    input  logic [dsc_pkg::MAG_W-1:0]        i_mag_b,
    output dsc_pkg::t_stage_ctl              o_ctl,
    output logic [dsc_pkg::MAG_W-1:0]        o_mag_a,
    output logic [dsc_pkg::MAG_W-1:0]        o_mag_b
);

    dsc_pkg::t_stage_ctl               r_ctl;
    dsc_pkg::t_stage_ctl               n_ctl;
    logic [dsc_pkg::MAG_W-1:0]         r_mag_a;
    logic [dsc_pkg::MAG_W-1:0]         r_mag_b;
    logic [dsc_pkg::MAG_W-1:0]         n_mag_a;
    logic [dsc_pkg::MAG_W+3:0]         prod;

    assign prod = {1'b0, i_mag_a, 3'b000} + {3'b000, i_mag_a, 1'b0};

    always_comb begin
        n_ctl   = i_ctl;
        n_mag_a = i_mag_a;
        if (i_ctl.cnt != '0 && !i_ctl.ovf) begin
            n_ctl.cnt = i_ctl.cnt - 1'b1;
            if (prod[dsc_pkg::MAG_W+3:dsc_pkg::MAG_W] != 4'd0) begin
                n_ctl.ovf = 1'b1;
            end else begin
                n_mag_a = prod[dsc_pkg::MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
        if (i_en) begin
            r_mag_a <= n_mag_a;
            r_mag_b <= i_mag_b;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;

endmodule

[rtl/core/decimal128_scaled_compare.sv]
// Top level of the scaled decimal comparator pipeline.
// The slave stream carries one pair of fixed-scale 128-bit decimals per transaction.
// The master stream returns one order code per transaction: less, equal or greater.
// A scale above MAX_SCALE is treated as MAX_SCALE.
// The first stage takes magnitudes and picks the side with the smaller scale.
// A chain of MAX_SCALE stages then multiplies that side by ten once per stage
// until the scales match, marking overflow when the product leaves 128 bits.
// The last stage orders the pair by sign, overflow mark and magnitude and registers the result.
// A transaction passes the first-stage register, the chain and the output register before its result is shown.
// Throughput is one transaction per cycle while the receiver does not stall; the chain of
// ten-multipliers sets the latency and each stage holds one wide add.
// Reset clears all valid bits, so the pipeline comes out of reset empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready falls; nothing is lost or repeated.
module decimal128_scaled_compare #(
    parameter int MAX_SCALE = 38
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // Fields from bit 0: left_high, left_low, left_scale, right_high, right_low,
    // right_scale, zero padding.
    input  logic [dsc_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Fields from bit 0: order, zero padding.
    output logic [dsc_pkg::OUT_W-1:0]    m_axis_tdata
);

    localparam int MW = dsc_pkg::MAG_W;
    localparam int SW = dsc_pkg::SCALE_W;

    logic                  en;
    logic [MW-1:0]         lval;
    logic [MW-1:0]         rval;
    logic [SW-1:0]         ls_raw;
    logic [SW-1:0]         rs_raw;
    logic [SW-1:0]         ls;
    logic [SW-1:0]         rs;
    logic                  lneg;
    logic                  rneg;
    logic [MW-1:0]         lmag;
    logic [MW-1:0]         rmag;

    dsc_pkg::t_stage_ctl   n_ctl0;
    dsc_pkg::t_stage_ctl   r_ctl0;
    logic [MW-1:0]         n_a0;
    logic [MW-1:0]         n_b0;
    logic [MW-1:0]         r_a0;
    logic [MW-1:0]         r_b0;

    dsc_pkg::t_stage_ctl   ctl  [MAX_SCALE+1];
    logic [MW-1:0]         mag_a[MAX_SCALE+1];
    logic [MW-1:0]         mag_b[MAX_SCALE+1];

    dsc_pkg::t_stage_ctl   fc;
    logic [MW-1:0]         fl;
    logic [MW-1:0]         fr;
    dsc_pkg::t_order       n_order;
    dsc_pkg::t_order       r_order;
    logic                  r_out_valid;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    assign lval   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign ls_raw = s_axis_tdata[133:128];
    assign rval   = {s_axis_tdata[197:134], s_axis_tdata[261:198]};
    assign rs_raw = s_axis_tdata[267:262];

    assign ls   = (ls_raw > SW'(MAX_SCALE)) ? SW'(MAX_SCALE) : ls_raw;
    assign rs   = (rs_raw > SW'(MAX_SCALE)) ? SW'(MAX_SCALE) : rs_raw;
    assign lneg = lval[MW-1];
    assign rneg = rval[MW-1];
    assign lmag = lneg ? (~lval + 1'b1) : lval;
    assign rmag = rneg ? (~rval + 1'b1) : rval;

    always_comb begin
        n_ctl0.valid     = s_axis_tvalid;
        n_ctl0.ovf       = 1'b0;
        n_ctl0.neg       = lneg;
        n_ctl0.lneg      = lneg;
        n_ctl0.sign_diff = lneg != rneg;
        if (ls > rs) begin
            n_ctl0.swap = 1'b1;
            n_ctl0.cnt  = ls - rs;
            n_a0        = rmag;
            n_b0        = lmag;
        end else begin
            n_ctl0.swap = 1'b0;
            n_ctl0.cnt  = rs - ls;
            n_a0        = lmag;
            n_b0        = rmag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0.valid <= 1'b0;
        end else if (en) begin
            r_ctl0 <= n_ctl0;
        end
        if (en) begin
            r_a0 <= n_a0;
            r_b0 <= n_b0;
        end
    end

    assign ctl[0]   = r_ctl0;
    assign mag_a[0] = r_a0;
    assign mag_b[0] = r_b0;

    for (genvar g = 0; g < MAX_SCALE; g++) begin : g_stage
        dsc_mul10_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[g]),
            .i_mag_a (mag_a[g]),
            .i_mag_b (mag_b[g]),
            .o_ctl   (ctl[g+1]),
            .o_mag_a (mag_a[g+1]),
            .o_mag_b (mag_b[g+1])
        );
    end

    assign fc = ctl[MAX_SCALE];
    assign fl = fc.swap ? mag_b[MAX_SCALE] : mag_a[MAX_SCALE];
    assign fr = fc.swap ? mag_a[MAX_SCALE] : mag_b[MAX_SCALE];

    always_comb begin
        if (fc.sign_diff) begin
            n_order = fc.lneg ? dsc_pkg::ORDER_LESS : dsc_pkg::ORDER_GREATER;
        end else if (fc.ovf) begin
            n_order = (fc.swap ^ fc.neg) ? dsc_pkg::ORDER_LESS : dsc_pkg::ORDER_GREATER;
        end else if (fl == fr) begin
            n_order = dsc_pkg::ORDER_EQUAL;
        end else if ((fl < fr) ^ fc.neg) begin
            n_order = dsc_pkg::ORDER_LESS;
        end else begin
            n_order = dsc_pkg::ORDER_GREATER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fc.valid;
        end
        if (en) begin
            r_order <= n_order;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_order};

endmodule

[rtl/core/dsc_checker.sv]
// Port-level checker for the scaled decimal comparator, bound to the top level.
module dsc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [dsc_pkg::OUT_W-1:0] m_axis_tdata
);

    a_order_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[7:2] == 6'd0))
        else $error("Invalid order code on the master stream.");

    a_ready_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("Input refused while the output register was free.");

    a_stall_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("Input accepted while the output was stalled.");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("Stalled result changed.");

endmodule

bind decimal128_scaled_compare dsc_checker u_dsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[dv/decimal128_scaled_compare_tb.sv]
// Testbench for the scaled decimal comparator: random and directed pairs against a predictor.
`timescale 1ns / 1ps
module decimal128_scaled_compare_tb;

    typedef struct packed {
        logic [63:0]                 lhi;
        logic [63:0]                 llo;
        logic [dsc_pkg::SCALE_W-1:0] ls;
        logic [63:0]                 rhi;
        logic [63:0]                 rlo;
        logic [dsc_pkg::SCALE_W-1:0] rs;
    } t_pair;

    localparam int LATENCY     = 40;
    localparam int WATCHDOG    = 5000;
    localparam int HOLD_CYCLES = 300;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    // Fields from bit 0: left_high, left_low, left_scale, right_high, right_low,
    // right_scale, zero padding.
    logic [dsc_pkg::IN_W-1:0]    s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    // Fields from bit 0: order, zero padding.
    logic [dsc_pkg::OUT_W-1:0]   m_axis_tdata;

    t_pair            pending_pairs[$];
    dsc_pkg::t_order  expected_orders[$];
    int               mismatches = 0;
    int               send_idle;
    int               recv_idle;
    int               hold_cnt;
    bit               hold_req;
    int               quiet_cycles = 0;

    decimal128_scaled_compare uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [6:0] clamp(logic [dsc_pkg::SCALE_W-1:0] s);
        return (s > 38) ? 7'd38 : {1'b0, s};
    endfunction

    function automatic logic [127:0] abs128(logic [127:0] v);
        return v[127] ? (~v + 128'd1) : v;
    endfunction

    function automatic t_pair unpack_pair(logic [dsc_pkg::IN_W-1:0] d);
        t_pair p;
        p.lhi = d[63:0];
        p.llo = d[127:64];
        p.ls  = d[133:128];
        p.rhi = d[197:134];
        p.rlo = d[261:198];
        p.rs  = d[267:262];
        return p;
    endfunction

    function automatic dsc_pkg::t_order order_of(t_pair p);
        logic [127:0] lm, rm;
        logic [131:0] prod;
        logic [6:0]   a, b;
        logic         ovf;
        int           c;
        bit           ln, rn;
        ln = p.lhi[63];
        rn = p.rhi[63];
        if (ln != rn) return ln ? dsc_pkg::ORDER_LESS : dsc_pkg::ORDER_GREATER;
        lm = abs128({p.lhi, p.llo});
        rm = abs128({p.rhi, p.rlo});
        a = clamp(p.ls);
        b = clamp(p.rs);
        ovf = 1'b0;
        if (a > b) begin
            for (int i = b; i < a && !ovf; i++) begin
                prod = rm * 132'd10;
                if (prod[131:128] != 0) ovf = 1'b1;
                else rm = prod[127:0];
            end
            c = ovf ? -1 : 0;
        end else begin
            for (int i = a; i < b && !ovf; i++) begin
                prod = lm * 132'd10;
                if (prod[131:128] != 0) ovf = 1'b1;
                else lm = prod[127:0];
            end
            c = ovf ? 1 : 0;
        end
        if (!ovf) c = (lm < rm) ? -1 : (lm > rm) ? 1 : 0;
        if (ln) c = -c;
        return (c < 0) ? dsc_pkg::ORDER_LESS :
               (c > 0) ? dsc_pkg::ORDER_GREATER : dsc_pkg::ORDER_EQUAL;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = 64'd0;
            1: v = '1;
            2: v = v >> $urandom_range(1, 63);
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        p.lhi = rand64();
        p.llo = rand64();
        p.ls  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(39, 63))
                                            : 6'($urandom_range(0, 38));
        p.rs  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(39, 63))
                                            : 6'($urandom_range(0, 38));
        case ($urandom_range(0, 3))
            0: begin
                p.rhi = p.lhi;
                p.rlo = p.llo;
                p.rs  = p.ls;
            end
            1: begin
                p.rhi = {64{p.lhi[63]}};
                p.rlo = 64'($urandom);
                p.lhi = {64{p.rhi[63]}};
            end
            default: begin
                p.rhi = rand64();
                p.rlo = rand64();
            end
        endcase
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic add_pair(logic [63:0] lhi, logic [63:0] llo, logic [5:0] ls,
                            logic [63:0] rhi, logic [63:0] rlo, logic [5:0] rs);
        t_pair p;
        p = '{lhi, llo, ls, rhi, rlo, rs};
        pending_pairs.push_back(p);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_orders.push_back(order_of(unpack_pair(s_axis_tdata)));
        end
    end

    always @(posedge i_clk) begin
        t_pair p;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    p = pending_pairs.pop_front();
                    s_axis_tdata  <= {4'd0, p.rs, p.rlo, p.rhi, p.ls, p.llo, p.lhi};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= 0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt      <= hold_cnt + 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        dsc_pkg::t_order want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_orders.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, -1);
                end else begin
                    want = expected_orders.pop_front();
                    if (m_axis_tdata[1:0] != want)
                        report_mismatch("order", m_axis_tdata[1:0], want);
                    if (m_axis_tdata[dsc_pkg::OUT_W-1:2] != 0)
                        report_mismatch("padding", m_axis_tdata, 0);
                end
            end
            if (quiet_cycles > WATCHDOG) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        send_idle = 27;
        recv_idle = 76;
        hold_req  = 1'b0;
        i_rst_n   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_pair(0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 38, 0, 0, 0);
        add_pair(64'h8000000000000000, 0, 0, 64'h8000000000000000, 0, 0);
        add_pair(64'h8000000000000000, 0, 0, 64'h7fffffffffffffff, '1, 0);
        add_pair(64'h7fffffffffffffff, '1, 0, 64'h7fffffffffffffff, '1, 38);
        add_pair(64'h7fffffffffffffff, '1, 38, 64'h7fffffffffffffff, '1, 0);
        add_pair(64'h8000000000000000, 0, 0, 64'h8000000000000000, 0, 38);
        add_pair(64'h8000000000000000, 0, 38, 64'h8000000000000000, 0, 0);
        add_pair('1, '1, 0, 0, 0, 0);
        add_pair(0, 0, 0, '1, '1, 0);
        add_pair(0, 10, 1, 0, 1, 0);
        add_pair(0, 11, 1, 0, 1, 0);
        add_pair('1, -64'sd11, 1, '1, '1, 0);
        add_pair(0, 5, 63, 0, 5, 38);
        add_pair(0, 5, 39, 0, 50, 63);
        add_pair(0, 1, 0, 0, 1, 63);
        add_pair('1, '1, 63, '1, '1, 0);
        add_pair(0, 64'd1000000000000000000, 18, 0, 1, 0);
        for (int i = 0; i < 200; i++) pending_pairs.push_back(random_pair());
        wait (pending_pairs.size() == 0 && !s_axis_tvalid);
        wait (expected_orders.size() == 0);

        send_idle = 76;
        recv_idle = 27;
        for (int i = 0; i < 200; i++) pending_pairs.push_back(random_pair());
        wait (pending_pairs.size() == 0 && !s_axis_tvalid);
        wait (expected_orders.size() == 0);

        send_idle = 0;
        recv_idle = 0;
        @(posedge i_clk);
        hold_req <= 1'b1;
        for (int i = 0; i < 200; i++) pending_pairs.push_back(random_pair());
        wait (pending_pairs.size() == 0 && !s_axis_tvalid);
        wait (expected_orders.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (mismatches == 0 && expected_orders.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[decimal128_scaled_compare.f]
rtl/core/dsc_pkg.sv
rtl/core/dsc_mul10_stage.sv
rtl/core/decimal128_scaled_compare.sv
rtl/core/dsc_checker.sv
dv/decimal128_scaled_compare_tb.sv
